// ----- rtl/core/vln_pkg.sv -----
// Shared constants and types for the vector L2 normalizer.
// Used by vln_fifo, vln_front, vln_back and the top level; depends on nothing else.
`timescale 1ns / 1ps

package vln_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_LEN_DEF     = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Depth of the internal queues (job queue and result queue).
  localparam int unsigned QUEUE_DEPTH = 2;

  // Vector length register.
  localparam int unsigned        LEN_W     = 7;
  localparam logic [LEN_W-1:0]   LEN_RESET = 7'd64;

  // Result format: signed Q1.15.
  localparam int unsigned        OUT_W      = 16;
  localparam int unsigned        STEP_W     = $clog2(OUT_W);
  localparam int unsigned        FRAC_SHIFT = 2 * (OUT_W - 1);
  localparam logic [OUT_W-1:0]   POS_LIMIT  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]   NEG_LIMIT  = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
  } result_t;

endpackage

// ----- rtl/core/vln_fifo.sv -----
// Small first-in first-out queue of any packed entry type.
// Depends on vln_pkg for its default depth.
`timescale 1ns / 1ps

module vln_fifo #(
  parameter int unsigned DEPTH = vln_pkg::QUEUE_DEPTH,
  parameter type         entry_t = logic
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/vln_store.sv -----
// Two-bank element memory: one write port, one registered read port.
// Bank selects which vector buffer; depends on nothing else.
`timescale 1ns / 1ps

module vln_store #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic                                     wr_bank_i,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_idx_i,
  input  logic [SAMPLE_BITS-1:0]                   wr_data_i,
  input  logic                                     rd_en_i,
  input  logic                                     rd_bank_i,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_idx_i,
  output logic [SAMPLE_BITS-1:0]                   rd_data_o
);

  localparam int unsigned MEM_AW = $clog2(2 * MAX_LEN);

  logic [SAMPLE_BITS-1:0] mem_q [2 * MAX_LEN];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [MEM_AW-1:0]      wr_addr, rd_addr;

  // The second bank starts at MAX_LEN, which need not be a power of two.
  assign wr_addr = MEM_AW'(wr_idx_i) + (wr_bank_i ? MEM_AW'(MAX_LEN) : '0);
  assign rd_addr = MEM_AW'(rd_idx_i) + (rd_bank_i ? MEM_AW'(MAX_LEN) : '0);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/vln_front.sv -----
// Load side: accepts elements, writes them to the store and accumulates
// the sum of squares. Hands a finished vector to the back as a job.
// Depends on vln_pkg.
`timescale 1ns / 1ps

module vln_front #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter type         job_t       = logic
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  output logic                                     full_o,
  input  logic [SAMPLE_BITS-1:0]                   elem_i,
  input  logic                                     len_we_i,
  input  logic [vln_pkg::LEN_W-1:0]                len_i,
  output logic                                     wr_en_o,
  output logic                                     wr_bank_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_idx_o,
  output logic [SAMPLE_BITS-1:0]                   wr_data_o,
  output logic                                     job_push_o,
  output job_t                                     job_o,
  input  logic                                     job_full_i,
  input  logic                                     vec_done_i
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CMP_W = (CNT_W > vln_pkg::LEN_W) ? CNT_W : vln_pkg::LEN_W;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_LEN);

  logic [vln_pkg::LEN_W-1:0] len_q;
  logic [CNT_W-1:0]          count_q, count_d, count_next;
  logic                      bank_q, bank_d;
  logic [1:0]                busy_q, busy_d;
  logic [CMP_W-1:0]          len_ext, eff_len;
  logic                      accept, last;
  logic [SAMPLE_BITS-1:0]    mag;

  logic                      s1_vld_q, s1_last_q, s1_bank_q;
  logic [SAMPLE_BITS-1:0]    s1_mag_q;
  logic [CNT_W-1:0]          s1_len_q;
  logic                      s2_vld_q, s2_last_q, s2_bank_q;
  logic [SQ_W-1:0]           s2_sq_q;
  logic [CNT_W-1:0]          s2_len_q;
  logic [2*SAMPLE_BITS-1:0]  sq_full;
  logic [SUM_W-1:0]          sum_q, sum_d, sum_next;

  // Two vector buffers; the load side stalls while both hold unfinished vectors.
  assign full_o = (busy_q == 2'd2);
  assign accept = push_i & ~full_o;

  assign len_ext = CMP_W'(len_q);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_LEN)) begin
      eff_len = CMP_W'(MAX_LEN);
    end else begin
      eff_len = len_ext;
    end
  end

  assign count_next = count_q + 1'b1;
  assign last       = (CMP_W'(count_next) >= eff_len);
  assign mag        = elem_i[SAMPLE_BITS-1] ? (~elem_i + 1'b1) : elem_i;

  assign wr_en_o   = accept;
  assign wr_bank_o = bank_q;
  assign wr_idx_o  = count_q[AW-1:0];
  assign wr_data_o = elem_i;

  always_comb begin
    count_d = count_q;
    bank_d  = bank_q;
    if (accept) begin
      if (last) begin
        count_d = '0;
        bank_d  = ~bank_q;
      end else begin
        count_d = count_next;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if ((accept && last) && !vec_done_i) begin
      busy_d = busy_q + 1'b1;
    end else if (!(accept && last) && vec_done_i) begin
      busy_d = busy_q - 1'b1;
    end
  end

  assign sq_full  = s1_mag_q * s1_mag_q;
  assign sum_next = sum_q + SUM_W'(s2_sq_q);

  always_comb begin
    sum_d = sum_q;
    if (s2_vld_q) begin
      sum_d = s2_last_q ? '0 : sum_next;
    end
  end

  assign job_push_o = s2_vld_q & s2_last_q;
  always_comb begin
    job_o      = '0;
    job_o.sum  = sum_next;
    job_o.len  = s2_len_q;
    job_o.bank = s2_bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= vln_pkg::LEN_RESET;
      count_q  <= '0;
      bank_q   <= 1'b0;
      busy_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      if (len_we_i) begin
        len_q <= len_i;
      end
      count_q  <= count_d;
      bank_q   <= bank_d;
      busy_q   <= busy_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q  <= mag;
    s1_last_q <= last;
    s1_len_q  <= count_next;
    s1_bank_q <= bank_q;
    s2_sq_q   <= sq_full[SQ_W-1:0];
    s2_last_q <= s1_last_q;
    s2_len_q  <= s1_len_q;
    s2_bank_q <= s1_bank_q;
  end

  a_busy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q != 2'd3) else $error("buffer count out of range");

  a_job_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> !job_full_i) else $error("job queue overflow");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q == 2'd2 && !vec_done_i) |=> full_o) else $error("full released early");

endmodule

// ----- rtl/core/vln_back.sv -----
// Compute side: for each element of a queued vector, reads it back and finds
// the largest q with q*q*S <= e*e*2^30, one result bit per cycle.
// Depends on vln_pkg.
`timescale 1ns / 1ps

module vln_back #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter type         job_t       = logic
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     job_empty_i,
  input  job_t                                     job_i,
  output logic                                     job_pop_o,
  output logic                                     rd_en_o,
  output logic                                     rd_bank_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_idx_o,
  input  logic [SAMPLE_BITS-1:0]                   rd_data_i,
  input  logic                                     res_full_i,
  output logic                                     res_push_o,
  output vln_pkg::result_t                         res_o,
  output logic                                     vec_done_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_LEN);
  localparam int unsigned TW    = SUM_W + 33;
  localparam int unsigned OW    = vln_pkg::OUT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_ITER   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [SUM_W-1:0]            sum_q;
  logic [CNT_W-1:0]            len_q, idx_q;
  logic                        bank_q, neg_q, zero_q;
  logic [SAMPLE_BITS-1:0]      mag_q;
  logic [SQ_W-1:0]             sq_q;
  logic [2*SAMPLE_BITS-1:0]    sq_full;
  logic [TW-1:0]               t_q, v_q, p_q, trial, x_val;
  logic [vln_pkg::STEP_W-1:0]  step_q;
  logic [OW-1:0]               root_q, lim, value;
  logic                        take, idx_last;

  assign sq_full  = mag_q * mag_q;
  assign x_val    = TW'(sq_q) << vln_pkg::FRAC_SHIFT;
  // T tracks q*q*S, V tracks 2^(b+1)*q*S and P is S*4^b for trial bit b.
  assign trial    = t_q + v_q + p_q;
  assign take     = (trial <= x_val);
  assign idx_last = ((idx_q + 1'b1) == len_q);

  always_comb begin
    if (!neg_q) begin
      lim   = (root_q > vln_pkg::POS_LIMIT) ? vln_pkg::POS_LIMIT : root_q;
      value = lim;
    end else begin
      lim   = (root_q > vln_pkg::NEG_LIMIT) ? vln_pkg::NEG_LIMIT : root_q;
      value = ~lim + 1'b1;
    end
    if (zero_q) begin
      value = '0;
    end
  end

  assign job_pop_o  = (state_q == ST_IDLE) && !job_empty_i;
  assign rd_en_o    = (state_q == ST_READ);
  assign rd_bank_o  = bank_q;
  assign rd_idx_o   = idx_q[AW-1:0];
  assign res_push_o = (state_q == ST_EMIT) && !res_full_i;
  assign vec_done_o = res_push_o && idx_last;
  assign res_o.value = value;
  assign res_o.last  = idx_last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (!job_empty_i) state_d = ST_READ;
      ST_READ:   state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ITER;
      ST_ITER:   if (step_q == '0) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!res_full_i) begin
          state_d = idx_last ? ST_IDLE : ST_READ;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sum_q  <= job_i.sum;
        len_q  <= job_i.len;
        bank_q <= job_i.bank;
        idx_q  <= '0;
      end
      ST_LOAD: begin
        neg_q  <= rd_data_i[SAMPLE_BITS-1];
        zero_q <= (rd_data_i == '0);
        mag_q  <= rd_data_i[SAMPLE_BITS-1] ? (~rd_data_i + 1'b1) : rd_data_i;
      end
      ST_SQUARE: begin
        sq_q   <= sq_full[SQ_W-1:0];
        t_q    <= '0;
        v_q    <= '0;
        p_q    <= TW'(sum_q) << vln_pkg::FRAC_SHIFT;
        step_q <= vln_pkg::STEP_W'(OW - 1);
        root_q <= '0;
      end
      ST_ITER: begin
        root_q <= {root_q[OW-2:0], take};
        if (take) begin
          t_q <= trial;
          v_q <= (v_q >> 1) + p_q;
        end else begin
          v_q <= v_q >> 1;
        end
        p_q    <= p_q >> 2;
        step_q <= step_q - 1'b1;
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result queue overflow");

  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && step_q == '0) |=> (state_q == ST_EMIT))
    else $error("root search did not finish");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_done_o |-> (res_push_o && res_o.last)) else $error("vector end without last word");

endmodule

// ----- rtl/core/vector_l2_normalizer.sv -----
// Vector L2 normalizer: top level joining load side, store, job queue,
// compute side and result queue. Depends on vln_pkg and all rtl/core modules.
//
// Usage:
//   Input words (element_value_i, signed Q2.14) are written with push while
//   full is low, one per cycle. Once the configured number of elements has
//   arrived, every element of that vector comes out, in arrival order, as
//   element / L2 norm in signed Q1.15 (saturated at +32767), with
//   last_of_vector_o set on the final word. A zero vector gives zeros.
//   Results are read like a queue: the word is valid while empty is low and
//   is taken with pop. If the receiver stalls, the result queue fills, the
//   compute side waits, and once both element buffers hold vectors, full
//   rises and the input waits too. Nothing is dropped.
//   vector_length_i (clamped to 1..MAX_LEN) is written with vector_length_we_i.
// Operation:
//   The compute side handles one element at a time: a store read, a squaring
//   step and a bit-serial root search, then the hand-off. Two element buffers
//   let the next vector load while the previous one is being computed.
// Reset:
//   Queues and counters empty, vector length 64; no clearing pass is needed.
`timescale 1ns / 1ps

module vector_l2_normalizer #(
  parameter int unsigned MAX_LEN     = vln_pkg::MAX_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = vln_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_BITS-1:0]     element_value_i,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [vln_pkg::OUT_W-1:0]  normalized_value_o,
  output logic                              last_of_vector_o,
  input  logic                              vector_length_we_i,
  input  logic [vln_pkg::LEN_W-1:0]         vector_length_i
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_LEN);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] len;
    logic             bank;
  } job_t;

  logic                   wr_en, wr_bank, rd_en, rd_bank;
  logic [AW-1:0]          wr_idx, rd_idx;
  logic [SAMPLE_BITS-1:0] wr_data, rd_data;
  logic                   job_push, job_full, job_pop, job_empty;
  job_t                   job_in, job_out;
  logic                   res_push, res_full, vec_done;
  vln_pkg::result_t       res_in, res_out;

  vln_front #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .job_t      (job_t)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .elem_i    (element_value_i),
    .len_we_i  (vector_length_we_i),
    .len_i     (vector_length_i),
    .wr_en_o   (wr_en),
    .wr_bank_o (wr_bank),
    .wr_idx_o  (wr_idx),
    .wr_data_o (wr_data),
    .job_push_o(job_push),
    .job_o     (job_in),
    .job_full_i(job_full),
    .vec_done_i(vec_done)
  );

  vln_store #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_bank_i(wr_bank),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_bank_i(rd_bank),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  vln_fifo #(
    .entry_t(job_t)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  vln_back #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .job_t      (job_t)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .rd_en_o    (rd_en),
    .rd_bank_o  (rd_bank),
    .rd_idx_o   (rd_idx),
    .rd_data_i  (rd_data),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in),
    .vec_done_o (vec_done)
  );

  vln_fifo #(
    .entry_t(vln_pkg::result_t)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign normalized_value_o = res_out.value;
  assign last_of_vector_o   = res_out.last;

endmodule
